// File: src/lca_pkg.sv
// Shared types, constants and helpers for the life cellular automaton step block.
package lca_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam int unsigned REG_W       = 12;
    localparam int unsigned COORD_W     = 11;
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MIN_SIZE    = 3;

    localparam int unsigned RESET_WIDTH  = 1920;
    localparam int unsigned RESET_HEIGHT = 1080;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } lca_reg_idx_t;

    // Cell travelling from the counter stage to the rule stage
    typedef struct packed {
        logic               valid;
        logic               alive;
        logic               emit;
        logic               done;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } lca_stage_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               next_alive;
        logic               frame_done;
    } lca_result_t;

    // Clamp a size register to MIN_SIZE..hi and return the last index
    function automatic int unsigned clamp_last(logic [REG_W-1:0] v, int unsigned hi);
        int unsigned s;
        s = int'(v);
        if (s < MIN_SIZE) s = MIN_SIZE;
        if (s > hi) s = hi;
        return s - 1;
    endfunction

endpackage

// File: src/life_cellular_automaton_step.sv
// Top level of the streaming Game of Life (B3/S23) next-generation step.
// Takes one cell per clock in raster order and keeps that rate indefinitely
// while the result side takes its requests; the limit is the single
// read-modify-write of the line store memory, one entry per cycle. A cell
// accepted reaches the rule stage in the next cycle, when its column
// of the two line stores comes back from the memory, and its result is written
// into the result queue, which offers it on the m_ side. The
// result queue holds three entries, one of them kept for the cell in the rule
// stage; s_tready falls when the queued results and that cell fill it.
// Interior cells only are reported, with m_tlast on the last interior cell of
// the frame. A size write restarts the frame and must be made while the block
// is idle; the line stores are not cleared.
module life_cellular_automaton_step #(
    parameter int unsigned MAX_WIDTH  = lca_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = lca_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_index,
    input  logic [lca_pkg::REG_W-1:0]  cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] cell_alive
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // [10:0] out_col, [21:11] out_row, [22] next_alive
    output logic                       m_tlast    // frame_done
);
    import lca_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    logic          accept;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    logic [1:0]    line_data;
    lca_stage_t    stage;
    logic          push;
    lca_result_t   push_data;
    lca_result_t   out_data;
    logic          can_accept;

    assign s_tready = can_accept;
    assign accept   = s_tvalid && s_tready;

    lca_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .cell_in      (s_tdata[0]),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .stage        (stage)
    );

    // shift the column down: new cell becomes previous row, previous row moves down
    lca_line_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (stage.valid),
        .wr_addr (wr_addr),
        .wr_data ({stage.alive, line_data[1]}),
        .rd_data (line_data)
    );

    lca_rule u_rule (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (cfg_wr_en),
        .stage     (stage),
        .line_data (line_data),
        .push      (push),
        .result    (push_data)
    );

    lca_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .inflight   (stage.valid),
        .can_accept (can_accept),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {1'b0, out_data.next_alive, out_data.row, out_data.col};
    assign m_tlast = out_data.frame_done;

endmodule

// File: src/lca_raster_ctrl.sv
// Raster counters, size registers and the first pipeline stage.
module lca_raster_ctrl #(
    parameter int unsigned MAX_WIDTH  = lca_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = lca_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned CW         = $clog2(MAX_WIDTH),
    parameter int unsigned RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_index,
    input  logic [lca_pkg::REG_W-1:0]   cfg_wr_data,
    input  logic                        accept,
    input  logic                        cell_in,
    output logic [CW-1:0]               rd_addr,
    output logic [CW-1:0]               wr_addr,
    output lca_pkg::lca_stage_t         stage
);
    import lca_pkg::*;

    logic [CW-1:0]  last_col_reg, last_col_next;
    logic [RW-1:0]  last_row_reg, last_row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  s1_addr_reg;
    lca_stage_t     stage_reg, stage_next;
    logic           at_last_col, at_last_row;

    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (cfg_wr_en) begin
            unique case (lca_reg_idx_t'(cfg_wr_index))
                REG_FRAME_WIDTH:  last_col_next = CW'(clamp_last(cfg_wr_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: last_row_next = RW'(clamp_last(cfg_wr_data, MAX_HEIGHT));
                default: ;
            endcase
            // restart the frame
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb begin
        stage_next.valid = accept && !cfg_wr_en;
        stage_next.alive = cell_in;
        stage_next.emit  = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
        stage_next.done  = at_last_col && at_last_row;
        stage_next.col   = COORD_W'(col_reg - CW'(1));
        stage_next.row   = COORD_W'(row_reg - RW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= CW'(clamp_last(REG_W'(RESET_WIDTH), MAX_WIDTH));
            last_row_reg <= RW'(clamp_last(REG_W'(RESET_HEIGHT), MAX_HEIGHT));
            col_reg      <= '0;
            row_reg      <= '0;
            stage_reg    <= '0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            stage_reg    <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= col_reg;
        end
    end

    assign rd_addr = col_reg;
    assign wr_addr = s1_addr_reg;
    assign stage   = stage_reg;

`ifndef NO_ASSERTIONS
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col_reg)
        else $error("column count beyond frame width");
`endif

endmodule

// File: src/lca_line_mem.sv
// Two line stores packed side by side in one simple dual-port memory.
module lca_line_mem #(
    parameter int unsigned MAX_WIDTH = lca_pkg::DEF_MAX_WIDTH,
    parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [CW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [CW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    output logic [1:0]    rd_data
);
    import lca_pkg::*;

    // bit 1: previous row, bit 0: row before that
    logic [1:0] store_mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

`ifndef NO_ASSERTIONS
    // a column recurs no sooner than three cells later, so no forwarding is needed
    a_no_same_entry: assert property (@(posedge aclk)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to the same line store entry");
`endif

endmodule

// File: src/lca_rule.sv
// 3x3 window register and the B3/S23 next-state rule.
module lca_rule (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart,
    input  lca_pkg::lca_stage_t   stage,
    input  logic [1:0]            line_data,
    output logic                  push,
    output lca_pkg::lca_result_t  result
);
    import lca_pkg::*;

    // bits 0..2: column x-2, bits 3..5: column x-1; within a column row y-2 first
    logic [5:0] window_reg, window_next;
    logic [2:0] column;
    logic [3:0] count;
    logic       centre;

    assign column = {stage.alive, line_data[1], line_data[0]};
    assign centre = window_reg[4];

    always_comb begin
        count = 4'(window_reg[0]) + 4'(window_reg[1]) + 4'(window_reg[2])
              + 4'(window_reg[3]) + 4'(window_reg[5])
              + 4'(column[0]) + 4'(column[1]) + 4'(column[2]);
    end

    always_comb begin
        window_next = window_reg;
        if (restart) begin
            window_next = '0;
        end else if (stage.valid) begin
            window_next = {column, window_reg[5:3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else begin
            window_reg <= window_next;
        end
    end

    assign push              = stage.valid && stage.emit;
    assign result.col        = stage.col;
    assign result.row        = stage.row;
    assign result.next_alive = (count == 4'd3) || ((count == 4'd2) && centre);
    assign result.frame_done = stage.done;

endmodule

// File: src/lca_out_queue.sv
// Small result queue that decouples the output handshake from the pipeline.
module lca_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lca_pkg::lca_result_t  push_data,
    input  logic                  inflight,
    output logic                  can_accept,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lca_pkg::lca_result_t  out_data
);
    import lca_pkg::*;

    lca_result_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    // reserve a slot for the cell already in flight
    assign can_accept = ((QCNT_W+1)'(count_reg) + (QCNT_W+1)'(inflight))
                        < (QCNT_W+1)'(QUEUE_DEPTH);

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");
`endif

endmodule
